// File: rtl/mexp_pkg.sv
// shared types and constants for the modular exponentiation block
// controller state encoding, command and status bundles, register indexes
// no dependencies
package mexp_pkg;

	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_BIT,
		ST_MUL_Z,
		ST_SQUARE,
		ST_MUL_T,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;       // capture base, exponent copy and initial accumulator
		logic step;        // one double-and-add step of the shared multiplier
		logic load_mul_z;  // operands z * t
		logic load_sq;     // operands t * t, exponent shifts right
		logic store_t;
		logic store_z;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic special;        // exponent zero or modulus zero
		logic last;           // final step of the multiplier
		logic exp_bit0;
		logic exp_rest_zero;  // exponent has no bits above bit 0
		logic out_free;
	} status_t;

endpackage

// File: rtl/mexp_stream_if.sv
// valid/ready channels of the modular exponentiation block
// base channel and result channel; depends on nothing
interface mexp_base_if #(
	parameter int W = 64
);
	logic         valid;
	logic         ready;
	logic [W-1:0] base_value;

	modport source (output valid, output base_value, input ready);
	modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_result_if #(
	parameter int W = 64
);
	logic         valid;
	logic         ready;
	logic [W-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink   (input valid, input power_result, output ready);
endinterface

// File: rtl/mexp_ctrl.sv
// sequencer for right-to-left square-and-multiply
// drives mexp_pkg::cmd_t to the datapath, reads mexp_pkg::status_t
module mexp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mexp_pkg::status_t  stat,
	output mexp_pkg::cmd_t     cmd
);

	mexp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = stat.special ? mexp_pkg::ST_FINISH : mexp_pkg::ST_REDUCE;
				end
			end
			mexp_pkg::ST_REDUCE: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					cmd.store_t = 1'b1;
					state_d     = mexp_pkg::ST_BIT;
				end
			end
			mexp_pkg::ST_BIT: begin
				if (stat.exp_bit0) begin
					cmd.load_mul_z = 1'b1;
					state_d        = mexp_pkg::ST_MUL_Z;
				end else begin
					state_d = mexp_pkg::ST_SQUARE;
				end
			end
			mexp_pkg::ST_MUL_Z: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					cmd.store_z = 1'b1;
					state_d     = mexp_pkg::ST_SQUARE;
				end
			end
			mexp_pkg::ST_SQUARE: begin
				// no bits left after this one: z is the answer
				if (stat.exp_rest_zero) begin
					state_d = mexp_pkg::ST_FINISH;
				end else begin
					cmd.load_sq = 1'b1;
					state_d     = mexp_pkg::ST_MUL_T;
				end
			end
			mexp_pkg::ST_MUL_T: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					cmd.store_t = 1'b1;
					state_d     = mexp_pkg::ST_BIT;
				end
			end
			mexp_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = mexp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mexp_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mexp_pkg::ST_IDLE && in_valid) |=> (state_q != mexp_pkg::ST_IDLE))
		else $error("accepted transaction did not start work");
	a_finish_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mexp_pkg::ST_FINISH && stat.out_free) |=> (state_q == mexp_pkg::ST_IDLE))
		else $error("result handed over but controller did not return to idle");
`endif

endmodule

// File: rtl/mexp_dp.sv
// datapath: config registers, shared bit-serial modular multiplier, operands
// and output register; commands from mexp_ctrl, types from mexp_pkg
module mexp_dp #(
	parameter int W = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mexp_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [W-1:0]                      wr_data,
	input  logic [W-1:0]                      base_value,
	input  mexp_pkg::cmd_t                    cmd,
	output mexp_pkg::status_t                 stat,
	output logic [W-1:0]                      power_result,
	output logic                              out_valid,
	input  logic                              out_ready
);

	localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]     exp_cfg_q, mod_q;
	logic [W-1:0]     exp_q, t_q, z_q, a_q, b_q, r_q, res_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	logic [W-1:0] one_mod;
	logic [W:0]   dbl, sum;
	logic [W-1:0] dbl_red, r_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cfg_q <= '0;
			mod_q     <= W'(1);
		end else if (wr_en) begin
			case (wr_index)
				mexp_pkg::REG_EXPONENT: exp_cfg_q <= wr_data;
				mexp_pkg::REG_MODULUS:  mod_q     <= wr_data;
				default: ;
			endcase
		end
	end

	assign one_mod = (mod_q == W'(1)) ? '0 : W'(1);

	// r <- 2r + bit*a mod m, both partial sums stay below 2m
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, mod_q}) ? W'(dbl - {1'b0, mod_q}) : dbl[W-1:0];
		sum     = {1'b0, dbl_red} + (b_q[W-1] ? {1'b0, a_q} : '0);
		r_next  = (sum >= {1'b0, mod_q}) ? W'(sum - {1'b0, mod_q}) : sum[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			exp_q <= exp_cfg_q;
			b_q   <= base_value;
			a_q   <= one_mod;
			r_q   <= '0;
			if (exp_cfg_q == '0) begin
				z_q <= W'(1);
			end else if (mod_q == '0) begin
				z_q <= '0;
			end else begin
				z_q <= one_mod;
			end
		end else begin
			if (cmd.step) begin
				r_q <= r_next;
				b_q <= {b_q[W-2:0], 1'b0};
			end
			if (cmd.load_mul_z) begin
				a_q <= z_q;
				b_q <= t_q;
				r_q <= '0;
			end
			if (cmd.load_sq) begin
				a_q   <= t_q;
				b_q   <= t_q;
				r_q   <= '0;
				exp_q <= {1'b0, exp_q[W-1:1]};
			end
			if (cmd.store_t) begin
				t_q <= r_next;
			end
			if (cmd.store_z) begin
				z_q <= r_next;
			end
		end
		if (cmd.load_out) begin
			res_q <= z_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start || cmd.load_mul_z || cmd.load_sq) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= stat.last ? '0 : cnt_q + CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.special       = (exp_cfg_q == '0) || (mod_q == '0);
		stat.last          = (cnt_q == CNT_W'(W - 1));
		stat.exp_bit0      = exp_q[0];
		stat.exp_rest_zero = (exp_q[W-1:1] == '0);
		stat.out_free      = !out_valid_q || out_ready;
	end

	assign power_result = res_q;
	assign out_valid    = out_valid_q;

`ifndef NO_ASSERTIONS
	a_operands_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (r_q < mod_q) && (a_q < mod_q))
		else $error("multiplier operand not reduced below modulus");
	a_count_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && stat.last) |=> (cnt_q == '0))
		else $error("step counter did not wrap after last step");
`endif

endmodule

// File: rtl/modular_exponentiation.sv
// the base is reduced first; then for each exponent bit up to the highest set one, a set bit
// multiplies z by t, and every bit below the highest set one is followed by a squaring of t
// one transaction at a time; the next base can be taken in the cycle after the result is loaded
// exponent zero or modulus zero skip the multiplier and go straight to loading the result
// reset (arst_n low, asynchronous) clears exponent to 0, modulus to 1, idles controller
// top level; uses mexp_pkg, mexp_stream_if, mexp_ctrl and mexp_dp
module modular_exponentiation #(
	parameter int OPERAND_WIDTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mexp_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [OPERAND_WIDTH-1:0]          wr_data,
	mexp_base_if.sink                         in_ch,
	mexp_result_if.source                     out_ch
);

	mexp_pkg::cmd_t    cmd;
	mexp_pkg::status_t stat;

	mexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mexp_dp #(
		.W (OPERAND_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.base_value   (in_ch.base_value),
		.cmd          (cmd),
		.stat         (stat),
		.power_result (out_ch.power_result),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready)
	);

endmodule

// File: tb/tb.sv
// self-checking testbench for modular_exponentiation: random and directed bases under several
// exponent/modulus settings, each result checked against an in-bench square-and-multiply model
// depends on mexp_pkg, mexp_stream_if and the modular_exponentiation top level
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W           = 64;
	localparam int LATENCY_MAX = 2 * W * W + 4 * W;
	localparam int HOLD_CYCLES = 1500;
	localparam int WATCHDOG    = 4 * LATENCY_MAX + 2 * HOLD_CYCLES;

	logic                             clk;
	logic                             arst_n;
	logic                             wr_en;
	logic [mexp_pkg::CFG_INDEX_W-1:0] wr_index;
	logic [W-1:0]                     wr_data;

	mexp_base_if #(.W(W))   base_ch ();
	mexp_result_if #(.W(W)) result_ch ();

	modular_exponentiation #(
		.OPERAND_WIDTH(W)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.in_ch   (base_ch),
		.out_ch  (result_ch)
	);

	// shadow copy of the register file
	logic [W-1:0] cur_exponent;
	logic [W-1:0] cur_modulus;

	logic [W-1:0] pending_bases[$];
	logic [W-1:0] expected_powers[$];

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_armed;
	bit hold_done;
	int hold_cnt;
	int idle_cycles;

	int bases_sent;
	int powers_checked;
	int mismatches;
	int settings_used;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [W-1:0] predict_power(logic [W-1:0] b, logic [W-1:0] e,
			logic [W-1:0] m);
		logic [2*W-1:0] prod;
		logic [W-1:0]   acc;
		logic [W-1:0]   sq;
		logic [W-1:0]   bits_left;
		if (e == '0)
			return W'(1);
		if (m == '0)
			return '0;
		sq = b % m;
		acc = W'(1) % m;
		bits_left = e;
		while (bits_left != '0) begin
			if (bits_left[0]) begin
				prod = (2*W)'(acc) * (2*W)'(sq);
				acc = W'(prod % (2*W)'(m));
			end
			bits_left = bits_left >> 1;
			if (bits_left != '0) begin
				prod = (2*W)'(sq) * (2*W)'(sq);
				sq = W'(prod % (2*W)'(m));
			end
		end
		return acc;
	endfunction

	function automatic logic [W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// mostly short exponents keep the run time down; now and then a full-width one
	function automatic logic [W-1:0] rand_exponent();
		int len;
		logic [W-1:0] mask;
		case ($urandom_range(15))
			0: return '0;
			1: return W'(1);
			2: return rand_word();
			default: begin
				len = $urandom_range(2, 16);
				mask = (W'(1) << len) - W'(1);
				return (rand_word() & mask) | (W'(1) << (len - 1));
			end
		endcase
	endfunction

	function automatic logic [W-1:0] rand_modulus();
		logic [W-1:0] m;
		case ($urandom_range(9))
			0, 1: m = W'($urandom_range(1, 255));
			2: m = W'(1);
			3: m = '1;
			default: m = rand_word();
		endcase
		if (m == '0)
			m = W'(1);
		return m;
	endfunction

	// edges around the modulus and the field limits, otherwise full random
	function automatic logic [W-1:0] rand_base(logic [W-1:0] m);
		case ($urandom_range(11))
			0: return '0;
			1: return W'(1);
			2: return '1;
			3: return m - W'(1);
			4: return m;
			5: return m + W'(1);
			default: return rand_word();
		endcase
	endfunction

	// sender: holds an offered transaction until it is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			base_ch.valid <= 1'b0;
		end else if (!(base_ch.valid && !base_ch.ready)) begin
			if (base_ch.valid && base_ch.ready)
				void'(pending_bases.pop_front());
			if (pending_bases.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				base_ch.valid <= 1'b1;
				base_ch.base_value <= pending_bases[0];
			end else begin
				base_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off when armed
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			result_ch.ready <= 1'b0;
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_cnt != 0) begin
			result_ch.ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predicts on each accepted base, checks each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (base_ch.valid && base_ch.ready) begin
				expected_powers.push_back(predict_power(base_ch.base_value, cur_exponent,
					cur_modulus));
				bases_sent++;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_powers.size() == 0) begin
					$error("power_result unexpected: expected none, actual %h",
						result_ch.power_result);
					mismatches++;
				end else begin
					if (result_ch.power_result !== expected_powers[0]) begin
						$error("power_result mismatch: expected %h, actual %h",
							expected_powers[0], result_ch.power_result);
						mismatches++;
					end
					void'(expected_powers.pop_front());
					powers_checked++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((base_ch.valid && base_ch.ready) || (result_ch.valid && result_ch.ready)
				|| wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic [mexp_pkg::CFG_INDEX_W-1:0] idx,
			input logic [W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			mexp_pkg::REG_EXPONENT: cur_exponent = val;
			mexp_pkg::REG_MODULUS:  cur_modulus = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [W-1:0] e, input logic [W-1:0] m);
		write_reg(mexp_pkg::REG_EXPONENT, e);
		write_reg(mexp_pkg::REG_MODULUS, m);
		settings_used++;
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
			default: begin send_idle_pct = 33; recv_stall_pct = 33; end
		endcase
	endtask

	// every base gives exactly one result, so a short pause suffices once all are back
	task automatic drain();
		while (pending_bases.size() != 0 || base_ch.valid || expected_powers.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int n_items;
		logic [W-1:0] e;
		logic [W-1:0] m;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = mexp_pkg::REG_EXPONENT;
		wr_data = '0;
		base_ch.valid = 1'b0;
		base_ch.base_value = '0;
		result_ch.ready = 1'b0;
		hold_armed = 1'b0;
		cur_exponent = '0;
		cur_modulus = W'(1);
		bases_sent = 0;
		powers_checked = 0;
		mismatches = 0;
		settings_used = 1;
		set_idling(0);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: exponent zero with modulus one still gives 1
		pending_bases.push_back('0);
		pending_bases.push_back('1);
		drain();

		// exponent one: plain reduction, including a base at the modulus and one just below it
		set_idling(1);
		apply_settings(W'(1), '1);
		pending_bases.push_back('0);
		pending_bases.push_back(W'(1));
		pending_bases.push_back('1);
		pending_bases.push_back('1 - W'(1));
		drain();

		// modulus one collapses everything to zero
		set_idling(2);
		apply_settings(W'(2), W'(1));
		pending_bases.push_back('1);
		drain();

		// full-width exponent against a large prime modulus
		set_idling(3);
		apply_settings('1, '1 - W'(58));
		pending_bases.push_back(W'(2));
		pending_bases.push_back('1);
		drain();

		// exponent zero with an ordinary modulus
		set_idling(0);
		apply_settings('0, W'(7));
		pending_bases.push_back(W'(5));
		drain();

		// modulus zero gives 0, except that exponent zero still gives 1
		apply_settings(W'(5), '0);
		pending_bases.push_back(W'(3));
		drain();
		write_reg(mexp_pkg::REG_EXPONENT, '0);
		pending_bases.push_back(W'(9));
		drain();

		// only the top exponent bit set: all squarings, one multiply
		set_idling(2);
		apply_settings(W'(1) << (W - 1), (W'(1) << (W - 1)) + W'(29));
		pending_bases.push_back(rand_word());
		drain();

		set_idling(1);
		m = rand_word() | (W'(1) << (W - 1));
		apply_settings(W'(65537), m);
		pending_bases.push_back('0);
		pending_bases.push_back(W'(1));
		pending_bases.push_back(rand_word());
		pending_bases.push_back('1);
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			set_idling(phase);
			e = rand_exponent();
			m = rand_modulus();
			n_items = $urandom_range(6, 10);
			if (phase == 3 || phase == 9) begin
				e = rand_word() | (W'(1) << (W - 1));
				n_items = 3;
			end
			if (phase == 5) begin
				// long receiver hold-off while the sender keeps offering
				e = W'(3);
				send_idle_pct = 0;
				hold_armed = 1'b1;
			end
			apply_settings(e, m);
			for (int i = 0; i < n_items; i++)
				pending_bases.push_back(rand_base(m));
			drain();
		end

		repeat (LATENCY_MAX) @(negedge clk);
		if (expected_powers.size() != 0) begin
			$error("power_result missing: %0d results never arrived", expected_powers.size());
			mismatches++;
		end
		$display("checked %0d results from %0d bases over %0d exponent/modulus settings",
			powers_checked, bases_sent, settings_used);
		$display("included special exponents and moduli, full-width exponents and a long stall");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
